[rtl/hdq_rd_pkg.sv]
// Shared types, register indexes and constants of the HDQ read master.
package hdq_rd_pkg;

  localparam int unsigned TickW = 10;
  localparam int unsigned CntW  = TickW + 1;

  // Length of the end gap after the last read slot
  localparam logic [TickW-1:0] END_GAP_TICKS = 10'd200;

  // Configuration register indexes
  localparam logic [2:0] REG_BREAK_LOW   = 3'd0;
  localparam logic [2:0] REG_BREAK_HIGH  = 3'd1;
  localparam logic [2:0] REG_ONE_LOW     = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW    = 3'd3;
  localparam logic [2:0] REG_WRITE_BIT   = 3'd4;
  localparam logic [2:0] REG_TURNAROUND  = 3'd5;
  localparam logic [2:0] REG_SAMPLE_OFS  = 3'd6;
  localparam logic [2:0] REG_READ_BIT    = 3'd7;

  // Register reset values
  localparam logic [TickW-1:0] RST_BREAK_LOW  = 10'd200;
  localparam logic [TickW-1:0] RST_BREAK_HIGH = 10'd50;
  localparam logic [TickW-1:0] RST_ONE_LOW    = 10'd20;
  localparam logic [TickW-1:0] RST_ZERO_LOW   = 10'd100;
  localparam logic [TickW-1:0] RST_WRITE_BIT  = 10'd200;
  localparam logic [TickW-1:0] RST_TURNAROUND = 10'd170;
  localparam logic [TickW-1:0] RST_SAMPLE_OFS = 10'd58;
  localparam logic [TickW-1:0] RST_READ_BIT   = 10'd208;

  // Item kinds carried on the slave tuser
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_BRK_LO = 7'b0000010,
    PH_BRK_HI = 7'b0000100,
    PH_WRITE  = 7'b0001000,
    PH_TURN   = 7'b0010000,
    PH_READ   = 7'b0100000,
    PH_GAP    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0] break_low;
    logic [TickW-1:0] break_high;
    logic [TickW-1:0] one_low;
    logic [TickW-1:0] zero_low;
    logic [TickW-1:0] write_bit;
    logic [TickW-1:0] turnaround;
    logic [TickW-1:0] sample_ofs;
    logic [TickW-1:0] read_bit;
  } cfg_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy;
    logic       data_valid;
    logic [7:0] read_data;
    logic       start_rejected;
  } res_t;

  // A zero length counts as one tick
  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    at_least_one = (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

[rtl/hdq_rd_cfg.sv]
// Configuration register bank of the HDQ read master.
module hdq_rd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [hdq_rd_pkg::TickW-1:0] cfg_data_i,
  output hdq_rd_pkg::cfg_t             cfg_o
);

  hdq_rd_pkg::cfg_t cfg_d, cfg_q;

  // Decode the write index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hdq_rd_pkg::REG_BREAK_LOW:  cfg_d.break_low  = cfg_data_i;
        hdq_rd_pkg::REG_BREAK_HIGH: cfg_d.break_high = cfg_data_i;
        hdq_rd_pkg::REG_ONE_LOW:    cfg_d.one_low    = cfg_data_i;
        hdq_rd_pkg::REG_ZERO_LOW:   cfg_d.zero_low   = cfg_data_i;
        hdq_rd_pkg::REG_WRITE_BIT:  cfg_d.write_bit  = cfg_data_i;
        hdq_rd_pkg::REG_TURNAROUND: cfg_d.turnaround = cfg_data_i;
        hdq_rd_pkg::REG_SAMPLE_OFS: cfg_d.sample_ofs = cfg_data_i;
        hdq_rd_pkg::REG_READ_BIT:   cfg_d.read_bit   = cfg_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.break_low  <= hdq_rd_pkg::RST_BREAK_LOW;
      cfg_q.break_high <= hdq_rd_pkg::RST_BREAK_HIGH;
      cfg_q.one_low    <= hdq_rd_pkg::RST_ONE_LOW;
      cfg_q.zero_low   <= hdq_rd_pkg::RST_ZERO_LOW;
      cfg_q.write_bit  <= hdq_rd_pkg::RST_WRITE_BIT;
      cfg_q.turnaround <= hdq_rd_pkg::RST_TURNAROUND;
      cfg_q.sample_ofs <= hdq_rd_pkg::RST_SAMPLE_OFS;
      cfg_q.read_bit   <= hdq_rd_pkg::RST_READ_BIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/hdq_rd_seq.sv]
// Bit-timing sequencer: phase, tick counter and shift registers, one step per item.
module hdq_rd_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             cmd_i,
  input  logic [7:0]       addr_i,
  input  logic             line_i,
  input  hdq_rd_pkg::cfg_t cfg_i,
  output hdq_rd_pkg::res_t res_o
);

  hdq_rd_pkg::phase_e                phase_d, phase_q;
  logic [hdq_rd_pkg::TickW-1:0]      tick_d, tick_q;
  logic [2:0]                        bit_d, bit_q;
  logic [7:0]                        shift_d, shift_q;
  logic [7:0]                        rx_d, rx_q;
  logic [hdq_rd_pkg::CntW-1:0]       cnt;
  logic [hdq_rd_pkg::TickW-1:0]      rd_per, smp_raw, smp_ofs, low_time;
  logic                              valid, rejected;

  assign cnt     = {1'b0, tick_q} + hdq_rd_pkg::CntW'(1);
  assign rd_per  = hdq_rd_pkg::at_least_one(cfg_i.read_bit);
  assign smp_raw = hdq_rd_pkg::at_least_one(cfg_i.sample_ofs);
  assign smp_ofs = (smp_raw > rd_per) ? rd_per : smp_raw;

  // Advance the phase by one tick or start a transaction
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    rx_d     = rx_q;
    valid    = 1'b0;
    rejected = 1'b0;
    if (step_i) begin
      if (cmd_i == hdq_rd_pkg::CMD_START) begin
        if (phase_q == hdq_rd_pkg::PH_IDLE) begin
          phase_d = hdq_rd_pkg::PH_BRK_LO;
          tick_d  = '0;
          bit_d   = '0;
          shift_d = addr_i;
          rx_d    = '0;
        end else begin
          rejected = 1'b1;
        end
      end else begin
        unique case (phase_q)
          hdq_rd_pkg::PH_IDLE: ;
          hdq_rd_pkg::PH_BRK_LO: begin
            if (cnt >= {1'b0, hdq_rd_pkg::at_least_one(cfg_i.break_low)}) begin
              phase_d = hdq_rd_pkg::PH_BRK_HI;
              tick_d  = '0;
            end else begin
              tick_d = cnt[hdq_rd_pkg::TickW-1:0];
            end
          end
          hdq_rd_pkg::PH_BRK_HI: begin
            if (cnt >= {1'b0, hdq_rd_pkg::at_least_one(cfg_i.break_high)}) begin
              phase_d = hdq_rd_pkg::PH_WRITE;
              tick_d  = '0;
              bit_d   = '0;
            end else begin
              tick_d = cnt[hdq_rd_pkg::TickW-1:0];
            end
          end
          hdq_rd_pkg::PH_WRITE: begin
            if (cnt >= {1'b0, hdq_rd_pkg::at_least_one(cfg_i.write_bit)}) begin
              tick_d  = '0;
              shift_d = {1'b0, shift_q[7:1]};
              if (bit_q == 3'd7) begin
                bit_d = '0;
                // Skip the turnaround when its length is zero
                if (cfg_i.turnaround == '0) begin
                  phase_d = hdq_rd_pkg::PH_READ;
                end else begin
                  phase_d = hdq_rd_pkg::PH_TURN;
                end
              end else begin
                bit_d = bit_q + 3'd1;
              end
            end else begin
              tick_d = cnt[hdq_rd_pkg::TickW-1:0];
            end
          end
          hdq_rd_pkg::PH_TURN: begin
            if (cnt >= {1'b0, cfg_i.turnaround}) begin
              phase_d = hdq_rd_pkg::PH_READ;
              tick_d  = '0;
              bit_d   = '0;
            end else begin
              tick_d = cnt[hdq_rd_pkg::TickW-1:0];
            end
          end
          hdq_rd_pkg::PH_READ: begin
            // Sample the line at the slot offset
            if (cnt == {1'b0, smp_ofs}) begin
              rx_d[bit_q] = rx_q[bit_q] | line_i;
            end
            if (cnt >= {1'b0, rd_per}) begin
              tick_d = '0;
              if (bit_q == 3'd7) begin
                bit_d = '0;
                if (hdq_rd_pkg::END_GAP_TICKS == '0) begin
                  phase_d = hdq_rd_pkg::PH_IDLE;
                  valid   = 1'b1;
                end else begin
                  phase_d = hdq_rd_pkg::PH_GAP;
                end
              end else begin
                bit_d = bit_q + 3'd1;
              end
            end else begin
              tick_d = cnt[hdq_rd_pkg::TickW-1:0];
            end
          end
          hdq_rd_pkg::PH_GAP: begin
            if (cnt >= {1'b0, hdq_rd_pkg::END_GAP_TICKS}) begin
              phase_d = hdq_rd_pkg::PH_IDLE;
              tick_d  = '0;
              valid   = 1'b1;
            end else begin
              tick_d = cnt[hdq_rd_pkg::TickW-1:0];
            end
          end
          default: begin
            phase_d = hdq_rd_pkg::PH_IDLE;
            tick_d  = '0;
          end
        endcase
      end
    end
  end

  // Drive for the following tick, taken from the new state
  assign low_time = shift_d[0] ? cfg_i.one_low : cfg_i.zero_low;

  always_comb begin
    res_o.drive_enable   = 1'b0;
    res_o.drive_level    = 1'b0;
    res_o.busy           = (phase_d != hdq_rd_pkg::PH_IDLE);
    res_o.data_valid     = valid;
    res_o.read_data      = valid ? rx_d : 8'h00;
    res_o.start_rejected = rejected;
    case (phase_d)
      hdq_rd_pkg::PH_BRK_LO: res_o.drive_enable = 1'b1;
      hdq_rd_pkg::PH_BRK_HI: begin
        res_o.drive_enable = 1'b1;
        res_o.drive_level  = 1'b1;
      end
      hdq_rd_pkg::PH_WRITE: begin
        res_o.drive_enable = 1'b1;
        res_o.drive_level  = (tick_d >= low_time);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hdq_rd_pkg::PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      rx_q    <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      rx_q    <= rx_d;
    end
  end

endmodule

[rtl/hdq_single_wire_read_master_top.sv]
// Top level of the HDQ read master: input register, sequencer and result register.
//
//  channel   dir  tuser            tdata
//  s_axis    in   command          [7:0] address, [8] line_in
//  m_axis    out  data_valid       [0] drive_enable, [1] drive_level, [2] busy_res,
//                                  [10:3] read_data, [11] start_rejected
//  cfg       in   -                cfg_idx_i selects, cfg_data_i written on cfg_we_i
//
// One request a cycle is taken while the master side is not stalled; each result
// passes through the input register and the result register around the sequencer step.
// Reset clears the phase, counters, shift registers and both stage valids, and
// loads the timing registers with their defaults.
// A stalled master side holds the result; the input register still takes one
// further request before tready falls.
module hdq_single_wire_read_master_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] address, [8] line_in, [15:9] zero
  input  logic        s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] drive_enable, [1] drive_level, [2] busy_res,
                                     // [10:3] read_data, [11] start_rejected, [15:12] zero
  output logic        m_axis_tuser,  // [0] data_valid
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);

  hdq_rd_pkg::cfg_t cfg;
  hdq_rd_pkg::res_t res, res_q;
  logic             in_valid_q, out_valid_q;
  logic             in_cmd_q, in_line_q;
  logic [7:0]       in_addr_q;
  logic             step;

  // Move the held request into the result register when there is room
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  hdq_rd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hdq_rd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (in_cmd_q),
    .addr_i (in_addr_q),
    .line_i (in_line_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register: stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser;
      in_addr_q <= s_axis_tdata[7:0];
      in_line_q <= s_axis_tdata[8];
    end
  end

  // Result register: stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.data_valid;
  assign m_axis_tdata  = {4'b0000, res_q.start_rejected, res_q.read_data, res_q.busy,
                          res_q.drive_level, res_q.drive_enable};

  // A rejected start only happens while a transaction runs
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.start_rejected) |-> res_q.busy)
    else $error("rejected start reported while idle");

  // A finished byte leaves the block idle with the line released
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.data_valid) |-> (!res_q.busy && !res_q.drive_enable))
    else $error("byte completed while still busy or driving");

  // A high level is only ever driven
  a_level_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.drive_level) |-> res_q.drive_enable)
    else $error("drive level without drive enable");

  // A full pipeline with a stalled master side takes no request
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken while both stages are full");

endmodule
